[hdl/ppm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the PPM frame generator.
// No dependencies; used by every module of the block.
package ppm_pkg;

	localparam int CHANNEL_COUNT = 8;
	localparam int CENTRE_WIDTH  = 1500;

	localparam int CH_AW      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int WIDTH_W    = 16;
	localparam int GAP_W      = 10;
	localparam int FRAME_W    = 16;
	localparam int TOTAL_W    = 22;
	localparam int PTR_W      = 4;
	localparam int IDX_W      = 4;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIDTH_W-1:0] CENTRE      = WIDTH_W'(CENTRE_WIDTH);
	localparam logic [PTR_W:0]     CH_LIMIT    = (PTR_W + 1)'(CHANNEL_COUNT);
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(CHANNEL_COUNT * CENTRE_WIDTH);

	localparam logic [GAP_W-1:0]   GAP_RESET     = GAP_W'(400);
	localparam logic [FRAME_W-1:0] FRAME_RESET   = FRAME_W'(22500);
	localparam logic [WIDTH_W-1:0] WMIN_RESET    = WIDTH_W'(1000);
	localparam logic [WIDTH_W-1:0] WMAX_RESET    = WIDTH_W'(2000);
	localparam logic [TOTAL_W-1:0] GAP_SUM_RESET = TOTAL_W'(400 * (CHANNEL_COUNT + 1));

	typedef enum logic [OP_W-1:0] {
		OP_TICK,
		OP_WRITE,
		OP_START,
		OP_STOP
	} op_t;

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_PULSE,
		PH_GAP
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INVERT,
		CFG_GAP,
		CFG_FRAME,
		CFG_WMIN,
		CFG_WMAX
	} cfg_reg_t;

	typedef struct packed {
		logic               rd_en;
		logic [CH_AW-1:0]   a_addr;
		logic [CH_AW-1:0]   b_addr;
		logic               wr_en;
		logic [CH_AW-1:0]   wr_addr;
		logic [WIDTH_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] a_data;
		logic [WIDTH_W-1:0] b_data;
	} mem_rsp_t;

	function automatic logic [WIDTH_W-1:0] at_least_one(input logic [WIDTH_W-1:0] v);
		return (v == '0) ? WIDTH_W'(1) : v;
	endfunction

endpackage

[hdl/ppm_frame_generator.sv]
`timescale 1ns / 1ps
// PPM frame generator top level: frame sequencer, channel write path, output stage.
// Depends on ppm_pkg and ppm_width_mem.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per cycle: op selects a
//   microsecond tick, a channel width write, start or stop. Every item yields one
//   result on the output channel (out_valid / out_stall): the pin level after the
//   item and the stored width of channel_index (centre width when out of range).
//   Throughput is one item per cycle unless the output stalls. The width store has a
//   registered read; a pulse width or the old width of a written entry arrives in
//   the cycle after the item and is folded into the countdown and the width sum
//   through a bypass. Configuration writes (cfg_we, cfg_index, cfg_data) must be
//   made only while idle; the block does not enforce this. Reset stops the generator
//   with level_q low, loads the default registers and makes every channel read as
//   the centre width; per-entry valid bits in the store replace any clearing pass,
//   so items are accepted right after reset. When the receiver stalls, the output
//   register holds its item, one more item waits in the read stage, and in_stall
//   rises until the output moves.
module ppm_frame_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ppm_pkg::OP_W-1:0]          op,
	input  logic [ppm_pkg::IDX_W-1:0]         channel_index,
	input  logic [ppm_pkg::WIDTH_W-1:0]       channel_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pin_level,
	output logic [ppm_pkg::WIDTH_W-1:0]       channel_readback,
	input  logic                              cfg_we,
	input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration
	logic                            invert_q;
	logic [ppm_pkg::GAP_W-1:0]       gap_q;
	logic [ppm_pkg::FRAME_W-1:0]     frame_q;
	logic [ppm_pkg::WIDTH_W-1:0]     wmin_q;
	logic [ppm_pkg::WIDTH_W-1:0]     wmax_q;
	logic [ppm_pkg::TOTAL_W-1:0]     gap_sum_q;

	// sequencer state
	logic                            active_q;
	logic                            level_q;
	ppm_pkg::phase_t                 phase_q;
	logic [ppm_pkg::PTR_W-1:0]       ptr_q;
	logic [ppm_pkg::WIDTH_W-1:0]     ticks_q;
	logic                            pend_q;
	logic [ppm_pkg::TOTAL_W-1:0]     wt_q;
	logic                            wpend_q;

	// read stage and output stage
	logic                            valid_s1;
	logic                            level_s1;
	logic                            wr_s1;
	logic                            idx_ok_s1;
	logic [ppm_pkg::WIDTH_W-1:0]     val_s1;
	logic                            out_valid_q;
	logic                            pin_q;
	logic [ppm_pkg::WIDTH_W-1:0]     rb_q;

	ppm_pkg::mem_req_t               req;
	ppm_pkg::mem_rsp_t               rsp;

	logic                            accept;
	logic                            advance;
	logic                            idx_ok;
	logic [ppm_pkg::WIDTH_W-1:0]     clamp_lo;
	logic [ppm_pkg::WIDTH_W-1:0]     clamped;
	logic [ppm_pkg::WIDTH_W-1:0]     tl_eff;
	logic [ppm_pkg::TOTAL_W-1:0]     wt_eff;
	logic [ppm_pkg::TOTAL_W:0]       used;
	logic [ppm_pkg::PTR_W-1:0]       ptr_inc;
	logic [ppm_pkg::PTR_W-1:0]       ch;
	logic                            n_active;
	logic                            n_level;
	ppm_pkg::phase_t                 n_phase;
	logic [ppm_pkg::PTR_W-1:0]       n_ptr;
	logic [ppm_pkg::WIDTH_W-1:0]     n_ticks;
	logic                            n_load;
	logic                            n_wr;

	ppm_width_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign idx_ok   = {1'b0, channel_index} < ppm_pkg::CH_LIMIT;
	assign clamp_lo = (channel_value < wmin_q) ? wmin_q : channel_value;
	assign clamped  = (clamp_lo > wmax_q) ? wmax_q : clamp_lo;

	// bypass the width that the previous item fetched
	assign tl_eff = pend_q ? ppm_pkg::at_least_one(rsp.b_data) : ticks_q;
	assign wt_eff = wpend_q
		? (wt_q - ppm_pkg::TOTAL_W'(rsp.a_data) + ppm_pkg::TOTAL_W'(val_s1))
		: wt_q;
	assign used    = {1'b0, gap_sum_q} + {1'b0, wt_eff};
	assign ptr_inc = ptr_q + ppm_pkg::PTR_W'(1);
	assign ch      = ({1'b0, ptr_q} < ppm_pkg::CH_LIMIT) ? ptr_q : '0;

	always_comb begin
		n_active = active_q;
		n_level  = level_q;
		n_phase  = phase_q;
		n_ptr    = ptr_q;
		n_ticks  = tl_eff;
		n_load   = 1'b0;
		n_wr     = 1'b0;
		case (ppm_pkg::op_t'(op))
			ppm_pkg::OP_TICK: begin
				if (active_q) begin
					if (tl_eff > ppm_pkg::WIDTH_W'(1)) begin
						n_ticks = tl_eff - ppm_pkg::WIDTH_W'(1);
					end else begin
						case (phase_q)
							ppm_pkg::PH_PULSE: begin
								// width arrives from the store next cycle
								n_level = !invert_q;
								n_load  = 1'b1;
								n_phase = ppm_pkg::PH_GAP;
							end
							ppm_pkg::PH_GAP: begin
								n_level = invert_q;
								n_ptr   = ptr_inc;
								if ({1'b0, ptr_inc} < ppm_pkg::CH_LIMIT) begin
									n_ticks = ppm_pkg::at_least_one(
										ppm_pkg::WIDTH_W'(gap_q));
									n_phase = ppm_pkg::PH_PULSE;
								end else begin
									// stretch the last gap to fill the frame
									if (used < (ppm_pkg::TOTAL_W + 1)'(frame_q)) begin
										n_ticks = frame_q - used[ppm_pkg::FRAME_W-1:0];
									end else begin
										n_ticks = ppm_pkg::WIDTH_W'(1);
									end
									n_phase = ppm_pkg::PH_SYNC;
								end
							end
							default: begin
								n_level = invert_q;
								n_ticks = ppm_pkg::at_least_one(ppm_pkg::WIDTH_W'(gap_q));
								n_ptr   = '0;
								n_phase = ppm_pkg::PH_PULSE;
							end
						endcase
					end
				end
			end
			ppm_pkg::OP_WRITE: begin
				n_wr = idx_ok;
			end
			ppm_pkg::OP_START: begin
				if (!active_q) begin
					n_active = 1'b1;
					n_phase  = ppm_pkg::PH_SYNC;
					n_ptr    = '0;
					n_level  = 1'b0;
					n_ticks  = ppm_pkg::WIDTH_W'(1);
				end
			end
			default: begin
				n_active = 1'b0;
				n_level  = 1'b0;
			end
		endcase
	end

	always_comb begin
		req.rd_en   = accept;
		req.a_addr  = channel_index[ppm_pkg::CH_AW-1:0];
		req.b_addr  = ch[ppm_pkg::CH_AW-1:0];
		req.wr_en   = accept && n_wr;
		req.wr_addr = channel_index[ppm_pkg::CH_AW-1:0];
		req.wr_data = clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q  <= 1'b0;
			gap_q     <= ppm_pkg::GAP_RESET;
			frame_q   <= ppm_pkg::FRAME_RESET;
			wmin_q    <= ppm_pkg::WMIN_RESET;
			wmax_q    <= ppm_pkg::WMAX_RESET;
			gap_sum_q <= ppm_pkg::GAP_SUM_RESET;
		end else if (cfg_we) begin
			case (ppm_pkg::cfg_reg_t'(cfg_index))
				ppm_pkg::CFG_INVERT: invert_q <= cfg_data[0];
				ppm_pkg::CFG_GAP: begin
					gap_q     <= cfg_data[ppm_pkg::GAP_W-1:0];
					gap_sum_q <= ppm_pkg::TOTAL_W'(cfg_data[ppm_pkg::GAP_W-1:0]
						* (ppm_pkg::CHANNEL_COUNT + 1));
				end
				ppm_pkg::CFG_FRAME: frame_q <= cfg_data[ppm_pkg::FRAME_W-1:0];
				ppm_pkg::CFG_WMIN:  wmin_q  <= cfg_data[ppm_pkg::WIDTH_W-1:0];
				ppm_pkg::CFG_WMAX:  wmax_q  <= cfg_data[ppm_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			level_q  <= 1'b0;
			phase_q  <= ppm_pkg::PH_SYNC;
			ptr_q    <= '0;
			ticks_q  <= '0;
			pend_q   <= 1'b0;
			wt_q     <= ppm_pkg::TOTAL_RESET;
			wpend_q  <= 1'b0;
		end else begin
			if (accept) begin
				active_q <= n_active;
				level_q  <= n_level;
				phase_q  <= n_phase;
				ptr_q    <= n_ptr;
				ticks_q  <= n_ticks;
			end else if (pend_q) begin
				ticks_q <= tl_eff;
			end
			pend_q  <= accept && n_load;
			wt_q    <= wt_eff;
			wpend_q <= accept && n_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1  <= n_level;
			wr_s1     <= n_wr;
			idx_ok_s1 <= idx_ok;
			val_s1    <= clamped;
		end
		if (advance) begin
			pin_q <= level_s1;
			// own write wins over the read-first data
			if (wr_s1) begin
				rb_q <= val_s1;
			end else if (idx_ok_s1) begin
				rb_q <= rsp.a_data;
			end else begin
				rb_q <= ppm_pkg::CENTRE;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign pin_level        = pin_q;
	assign channel_readback = rb_q;

endmodule

[hdl/ppm_width_mem.sv]
`timescale 1ns / 1ps
// Channel width store: one write port, two registered read ports.
// Entries never written read as the centre width. Depends on ppm_pkg.
module ppm_width_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  ppm_pkg::mem_req_t  req,
	output ppm_pkg::mem_rsp_t  rsp
);

	logic [ppm_pkg::WIDTH_W-1:0]     mem_q [ppm_pkg::CHANNEL_COUNT];
	logic [ppm_pkg::CHANNEL_COUNT-1:0] valid_q;
	logic [ppm_pkg::WIDTH_W-1:0]     rd_a_q;
	logic [ppm_pkg::WIDTH_W-1:0]     rd_b_q;
	logic                            vld_a_q;
	logic                            vld_b_q;

	// read-first: a read at the written address returns the old entry
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_a_q <= mem_q[req.a_addr];
			rd_b_q <= mem_q[req.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				vld_a_q <= valid_q[req.a_addr];
				vld_b_q <= valid_q[req.b_addr];
			end
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rsp.a_data = vld_a_q ? rd_a_q : ppm_pkg::CENTRE;
	assign rsp.b_data = vld_b_q ? rd_b_q : ppm_pkg::CENTRE;

endmodule

[hdl/ppm_chk.sv]
`timescale 1ns / 1ps
// Port-level checks for the PPM frame generator, bound to the top level.
// Depends on ppm_pkg.
module ppm_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [ppm_pkg::OP_W-1:0]          op,
	input logic [ppm_pkg::IDX_W-1:0]         channel_index,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              pin_level,
	input logic [ppm_pkg::WIDTH_W-1:0]       channel_readback
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_stop_low: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == ppm_pkg::OP_STOP) ##1 !out_stall
		|=> out_valid && !pin_level)
		else $error("pin not low after stop");

	a_range_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall
			&& {1'b0, channel_index} >= ppm_pkg::CH_LIMIT) ##1 !out_stall
		|=> out_valid && channel_readback == ppm_pkg::CENTRE)
		else $error("out of range readback is not the centre width");

endmodule

bind ppm_frame_generator ppm_chk u_ppm_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.op               (op),
	.channel_index    (channel_index),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.pin_level        (pin_level),
	.channel_readback (channel_readback)
);
